// ----- sv/bitmap_set_clear_popcount_top_assert.svh -----
// Assertion macros used by the bit set store back end.
`ifndef BITMAP_SET_CLEAR_POPCOUNT_TOP_ASSERT_SVH
`define BITMAP_SET_CLEAR_POPCOUNT_TOP_ASSERT_SVH

// Property that must hold at every clock edge outside reset.
`define BSCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bscp assertion failed");

// Consequence that must hold in the cycle after the antecedent.
`define BSCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bscp next-cycle assertion failed");

`endif

// ----- sv/bscp_pkg.sv -----
// Types and constants of the bit set store.
package bscp_pkg;

   localparam int WORD_IDX_W = 11;
   localparam int BIT_POS_W  = 5;
   localparam int PAGE_IDX_W = 5;
   localparam int PAGE_CNT_W = 12;
   localparam int TOTAL_W    = 16;

   typedef enum logic [1:0] {
      ACT_SET   = 2'd0,
      ACT_RESET = 2'd1,
      ACT_COUNT = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef struct packed {
      action_type              action;
      logic                    oor;
      logic [WORD_IDX_W-1:0]   word;
      logic [BIT_POS_W-1:0]    bit_pos;
      logic [PAGE_IDX_W-1:0]   page;
   } cmd_type;

endpackage

// ----- sv/bscp_if.sv -----
// Request and response channel interfaces of the bit set store.
interface bscp_req_if;
   import bscp_pkg::*;

   logic                  valid;
   logic                  ready;
   action_type            action;
   logic [15:0]           bit_index;
   logic [PAGE_IDX_W-1:0] page_index;

   modport source (output valid, output action, output bit_index, output page_index,
                   input ready);
   modport sink   (input valid, input action, input bit_index, input page_index,
                   output ready);
endinterface

interface bscp_rsp_if;
   import bscp_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  changed;
   logic [PAGE_CNT_W-1:0] page_count;
   logic [TOTAL_W-1:0]    total_count;
   logic                  out_of_range;

   modport source (output valid, output changed, output page_count, output total_count,
                   output out_of_range, input ready);
   modport sink   (input valid, input changed, input page_count, input total_count,
                   input out_of_range, output ready);
endinterface

// ----- sv/bscp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bscp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                         wdata,
   input  logic                                     re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/bscp_front.sv -----
// Front end: accepts requests, classifies them and queues commands.
module bscp_front #(
   parameter int PAGE_WORDS  = 64,
   parameter int STORE_PAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   bscp_req_if.sink          req_bus,
   input  logic              init_busy,
   output bscp_pkg::cmd_type cmd,
   output logic              cmd_valid,
   input  logic              cmd_pop
);
   import bscp_pkg::*;

   localparam int unsigned STORE_WORDS = PAGE_WORDS * STORE_PAGES;

   cmd_type    q_ff [2];
   cmd_type    entry_in;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;

   assign req_bus.ready = (count_ff != 2'd2) && !init_busy;
   assign push          = req_bus.valid && req_bus.ready;
   assign cmd_valid     = (count_ff != 2'd0);
   assign cmd           = q_ff[rd_ptr_ff];

   always_comb begin
      entry_in.action  = req_bus.action;
      entry_in.word    = req_bus.bit_index[15:BIT_POS_W];
      entry_in.bit_pos = req_bus.bit_index[BIT_POS_W-1:0];
      entry_in.page    = req_bus.page_index;
      case (req_bus.action) inside
         ACT_SET, ACT_RESET: entry_in.oor = (32'(entry_in.word) >= STORE_WORDS);
         ACT_COUNT:          entry_in.oor = (32'(req_bus.page_index) >= 32'(STORE_PAGES));
         default:            entry_in.oor = 1'b0;
      endcase
   end

   always_comb begin
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ cmd_pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end
endmodule

// ----- sv/bscp_back.sv -----
// Back end: executes commands against the word store and returns results.
module bscp_back #(
   parameter int PAGE_WORDS  = 64,
   parameter int STORE_PAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  bscp_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   output logic              init_busy,
   bscp_rsp_if.source        rsp_bus
);
   import bscp_pkg::*;

   `include "bitmap_set_clear_popcount_top_assert.svh"

   localparam int STORE_WORDS = PAGE_WORDS * STORE_PAGES;
   localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int IW          = $clog2(PAGE_WORDS + 1);
   localparam logic [AW-1:0] LAST_ADDR  = AW'(STORE_WORDS - 1);
   localparam logic [IW-1:0] PAGE_ISSUE = IW'(PAGE_WORDS);
   localparam logic [31:0] M1 = 32'h5555_5555;
   localparam logic [31:0] M2 = 32'h3333_3333;
   localparam logic [31:0] M4 = 32'h0f0f_0f0f;
   localparam logic [31:0] M8 = 32'h00ff_00ff;

   typedef enum logic [4:0] {
      S_INIT  = 5'b00001,
      S_IDLE  = 5'b00010,
      S_RMW   = 5'b00100,
      S_COUNT = 5'b01000,
      S_CLEAR = 5'b10000
   } state_type;

   function automatic logic [5:0] pop32(input logic [31:0] u);
      logic [31:0] v;
      v = ((u >> 1) & M1) + (u & M1);
      v = ((v >> 2) & M2) + (v & M2);
      v = ((v >> 4) & M4) + (v & M4);
      v = ((v >> 8) & M8) + (v & M8);
      return 6'(v[31:16] + v[15:0]);
   endfunction

   state_type             state_ff, state_in;
   logic [AW-1:0]         addr_ff, addr_in;
   cmd_type               cmd_ff, cmd_in;
   logic [IW-1:0]         issued_ff, issued_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [PAGE_CNT_W-1:0] acc_ff, acc_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_changed_ff, rsp_changed_in;
   logic [PAGE_CNT_W-1:0] rsp_page_ff, rsp_page_in;
   logic [TOTAL_W-1:0]    rsp_total_ff, rsp_total_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic                  ram_we, ram_re;
   logic [AW-1:0]         ram_waddr, ram_raddr;
   logic [31:0]           ram_wdata, ram_rdata;
   logic                  out_free, load_rsp, flip;
   logic [31:0]           mask;

   bscp_ram #(.WIDTH(32), .DEPTH(STORE_WORDS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_bus.ready;
   assign init_busy = (state_ff == S_INIT);
   assign mask      = 32'(1) << cmd_ff.bit_pos;

   always_comb begin
      state_in       = state_ff;
      addr_in        = addr_ff;
      cmd_in         = cmd_ff;
      issued_in      = issued_ff;
      rd_pend_in     = 1'b0;
      acc_in         = acc_ff;
      total_in       = total_ff;
      rsp_changed_in = rsp_changed_ff;
      rsp_page_in    = rsp_page_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_oor_in     = rsp_oor_ff;
      ram_we         = 1'b0;
      ram_re         = 1'b0;
      ram_waddr      = addr_ff;
      ram_wdata      = '0;
      ram_raddr      = addr_ff;
      cmd_pop        = 1'b0;
      load_rsp       = 1'b0;
      flip           = 1'b0;

      case (state_ff)
         S_INIT: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == LAST_ADDR) begin
               addr_in        = '0;
               total_in       = '0;
               load_rsp       = 1'b1;
               rsp_changed_in = 1'b0;
               rsp_page_in    = '0;
               rsp_total_in   = '0;
               rsp_oor_in     = 1'b0;
               state_in       = S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.oor) begin
                  load_rsp       = 1'b1;
                  rsp_changed_in = 1'b0;
                  rsp_page_in    = '0;
                  rsp_total_in   = total_ff;
                  rsp_oor_in     = 1'b1;
               end else begin
                  case (cmd.action)
                     ACT_SET, ACT_RESET: begin
                        addr_in   = AW'(cmd.word);
                        ram_re    = 1'b1;
                        ram_raddr = AW'(cmd.word);
                        state_in  = S_RMW;
                     end
                     ACT_COUNT: begin
                        addr_in   = AW'(32'(cmd.page) * 32'(PAGE_WORDS));
                        issued_in = '0;
                        acc_in    = '0;
                        state_in  = S_COUNT;
                     end
                     ACT_CLEAR: begin
                        addr_in  = '0;
                        state_in = S_CLEAR;
                     end
                     default: begin
                        state_in = S_IDLE;
                     end
                  endcase
               end
            end
         end
         S_RMW: begin
            if (cmd_ff.action == ACT_SET) begin
               flip      = !ram_rdata[cmd_ff.bit_pos];
               ram_wdata = ram_rdata | mask;
               if (flip) begin
                  total_in = total_ff + TOTAL_W'(1);
               end
            end else begin
               flip      = ram_rdata[cmd_ff.bit_pos];
               ram_wdata = ram_rdata & ~mask;
               if (flip) begin
                  total_in = total_ff - TOTAL_W'(1);
               end
            end
            ram_we         = flip;
            load_rsp       = 1'b1;
            rsp_changed_in = flip;
            rsp_page_in    = '0;
            rsp_total_in   = total_in;
            rsp_oor_in     = 1'b0;
            state_in       = S_IDLE;
         end
         S_COUNT: begin
            if (issued_ff != PAGE_ISSUE) begin
               ram_re     = 1'b1;
               addr_in    = addr_ff + AW'(1);
               issued_in  = issued_ff + IW'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               acc_in = acc_ff + PAGE_CNT_W'(pop32(ram_rdata));
            end
            if (issued_ff == PAGE_ISSUE && !rd_pend_ff) begin
               load_rsp       = 1'b1;
               rsp_changed_in = 1'b0;
               rsp_page_in    = acc_ff;
               rsp_total_in   = total_ff;
               rsp_oor_in     = 1'b0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         addr_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_pend_ff   <= rd_pend_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff         <= cmd_in;
      issued_ff      <= issued_in;
      acc_ff         <= acc_in;
      rsp_changed_ff <= rsp_changed_in;
      rsp_page_ff    <= rsp_page_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.changed      = rsp_changed_ff;
   assign rsp_bus.page_count   = rsp_page_ff;
   assign rsp_bus.total_count  = rsp_total_ff;
   assign rsp_bus.out_of_range = rsp_oor_ff;

   `BSCP_ASSERT(a_write_states, clock, reset,
      ram_we |-> (state_ff == S_RMW || state_ff == S_INIT || state_ff == S_CLEAR))
   `BSCP_ASSERT(a_load_free, clock, reset, load_rsp |-> (!rsp_valid_ff || rsp_bus.ready))
   `BSCP_ASSERT(a_pop_idle, clock, reset, cmd_pop |-> (state_ff == S_IDLE && cmd_valid))
   `BSCP_ASSERT_NEXT(a_clear_done, clock, reset,
      (state_ff == S_CLEAR && addr_ff == LAST_ADDR), (total_ff == '0 && rsp_valid_ff))
endmodule

// ----- sv/bitmap_set_clear_popcount_top.sv -----
// Set or reset: RAM read in S_IDLE, read-modify-write in S_RMW, registered result; one command at a time.
// Out-of-range set, reset or count: result valid in the cycle after the back end takes it.
// Count page: one word per cycle through the single RAM read port.
// Clear all: one word zeroed per cycle.
// Reset: a clearing pass over all PAGE_WORDS * STORE_PAGES words, req_bus.ready low until it ends.
module bitmap_set_clear_popcount_top #(
   parameter int PAGE_WORDS  = 64,
   parameter int STORE_PAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   bscp_req_if.sink    req_bus,
   bscp_rsp_if.source  rsp_bus
);
   import bscp_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   logic    init_busy;

   bscp_front #(.PAGE_WORDS(PAGE_WORDS), .STORE_PAGES(STORE_PAGES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .init_busy (init_busy),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop)
   );

   bscp_back #(.PAGE_WORDS(PAGE_WORDS), .STORE_PAGES(STORE_PAGES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .init_busy (init_busy),
      .rsp_bus   (rsp_bus)
   );
endmodule

// ----- dv/tb_bitmap_set_clear_popcount_top.sv -----
// Self-checking testbench for the bit set store: directed steps, then random ops against a predictor.
module tb_bitmap_set_clear_popcount_top;
   timeunit 1ns;
   timeprecision 1ps;

   import bscp_pkg::*;

   localparam int PAGE_WORDS  = 64;
   localparam int STORE_PAGES = 16;
   localparam int STORE_WORDS = PAGE_WORDS * STORE_PAGES;
   localparam int RANDOM_OPS_PER_PHASE = 210;
   localparam int RECENT_DEPTH = 64;

   typedef struct packed {
      logic                  changed;
      logic [PAGE_CNT_W-1:0] page_count;
      logic [TOTAL_W-1:0]    total_count;
      logic                  out_of_range;
   } store_rsp_type;

   typedef struct packed {
      action_type            action;
      logic [15:0]           bit_index;
      logic [PAGE_IDX_W-1:0] page_index;
      logic                  fixed;
      store_rsp_type         rsp;
   } directed_step_type;

   logic clock;
   logic reset;

   bscp_req_if req_bus ();
   bscp_rsp_if rsp_bus ();

   bitmap_set_clear_popcount_top #(
      .PAGE_WORDS  (PAGE_WORDS),
      .STORE_PAGES (STORE_PAGES)
   ) DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow of the store
   logic [31:0]        shadow_words [STORE_WORDS];
   logic [TOTAL_W-1:0] shadow_bits_set;

   store_rsp_type expected_rsps [$];
   store_rsp_type oldest_rsp;
   logic [15:0] recent_set_bits [$];

   int unsigned send_idle_pct;
   int unsigned rcv_idle_pct;
   int unsigned mismatch_count;
   int unsigned action_tally [4];
   int unsigned oor_tally;
   int unsigned flip_tally;

   // fixed rows come straight from the spec; the rest go through the predictor
   directed_step_type directed_steps [24] = '{
      '{ACT_COUNT, 16'd0,     5'd0,  1'b1, '{1'b0, 12'd0, 16'd0, 1'b0}},
      '{ACT_COUNT, 16'd0,     5'd15, 1'b1, '{1'b0, 12'd0, 16'd0, 1'b0}},
      '{ACT_COUNT, 16'd0,     5'd16, 1'b1, '{1'b0, 12'd0, 16'd0, 1'b1}},
      '{ACT_COUNT, 16'd0,     5'd31, 1'b1, '{1'b0, 12'd0, 16'd0, 1'b1}},
      '{ACT_SET,   16'd0,     5'd0,  1'b1, '{1'b1, 12'd0, 16'd1, 1'b0}},
      '{ACT_SET,   16'd0,     5'd0,  1'b1, '{1'b0, 12'd0, 16'd1, 1'b0}},
      '{ACT_SET,   16'd32767, 5'd31, 1'b1, '{1'b1, 12'd0, 16'd2, 1'b0}},
      '{ACT_SET,   16'd32768, 5'd0,  1'b1, '{1'b0, 12'd0, 16'd2, 1'b1}},
      '{ACT_RESET, 16'd65535, 5'd0,  1'b1, '{1'b0, 12'd0, 16'd2, 1'b1}},
      '{ACT_SET,   16'd31,    5'd0,  1'b0, '0},
      '{ACT_SET,   16'd32,    5'd0,  1'b0, '0},
      '{ACT_SET,   16'd2047,  5'd0,  1'b0, '0},
      '{ACT_SET,   16'd2048,  5'd0,  1'b0, '0},
      '{ACT_COUNT, 16'd65535, 5'd0,  1'b0, '0},
      '{ACT_COUNT, 16'd0,     5'd15, 1'b0, '0},
      '{ACT_RESET, 16'd0,     5'd31, 1'b0, '0},
      '{ACT_RESET, 16'd0,     5'd0,  1'b0, '0},
      '{ACT_COUNT, 16'd0,     5'd1,  1'b0, '0},
      '{ACT_SET,   16'h5555,  5'd10, 1'b0, '0},
      '{ACT_SET,   16'haaaa,  5'd21, 1'b0, '0},
      '{ACT_CLEAR, 16'd65535, 5'd31, 1'b1, '{1'b0, 12'd0, 16'd0, 1'b0}},
      '{ACT_COUNT, 16'd0,     5'd15, 1'b1, '{1'b0, 12'd0, 16'd0, 1'b0}},
      '{ACT_RESET, 16'd32767, 5'd0,  1'b1, '{1'b0, 12'd0, 16'd0, 1'b0}},
      '{ACT_SET,   16'd65535, 5'd31, 1'b1, '{1'b0, 12'd0, 16'd0, 1'b1}}
   };

   function automatic store_rsp_type apply_to_store(action_type act, logic [15:0] bidx,
                                                    logic [PAGE_IDX_W-1:0] pidx);
      store_rsp_type r;
      int unsigned   word;
      logic          bit_now;
      r = '0;
      case (act)
         ACT_SET, ACT_RESET: begin
            word = 32'(bidx[15:5]);
            if (word >= STORE_WORDS) begin
               r.out_of_range = 1'b1;
            end else begin
               bit_now = shadow_words[word][bidx[4:0]];
               if (bit_now != (act == ACT_SET)) begin
                  shadow_words[word][bidx[4:0]] = (act == ACT_SET);
                  shadow_bits_set = (act == ACT_SET) ? shadow_bits_set + 16'd1
                                                     : shadow_bits_set - 16'd1;
                  r.changed = 1'b1;
               end
            end
         end
         ACT_COUNT: begin
            if (pidx >= STORE_PAGES) begin
               r.out_of_range = 1'b1;
            end else begin
               for (int n = 0; n < PAGE_WORDS; n++)
                  r.page_count = r.page_count
                     + PAGE_CNT_W'($countones(shadow_words[pidx * PAGE_WORDS + n]));
            end
         end
         default: begin
            foreach (shadow_words[i]) shadow_words[i] = '0;
            shadow_bits_set = '0;
         end
      endcase
      r.total_count = shadow_bits_set;
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      $display("tb: mismatch at %0t on %s: got %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   // one transfer on the request side, with a random hold-off before it
   task automatic send_op(action_type act, logic [15:0] bidx, logic [PAGE_IDX_W-1:0] pidx,
                          logic fixed, store_rsp_type fixed_rsp);
      store_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.action     <= act;
      req_bus.bit_index  <= bidx;
      req_bus.page_index <= pidx;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_to_store(act, bidx, pidx);
      expected_rsps.push_back(fixed ? fixed_rsp : predicted);
      action_tally[act]++;
      oor_tally  += 32'(predicted.out_of_range);
      flip_tally += 32'(predicted.changed);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            oldest_rsp = expected_rsps.pop_front();
            if (rsp_bus.changed !== oldest_rsp.changed)
               report_mismatch("changed", rsp_bus.changed, oldest_rsp.changed);
            if (rsp_bus.page_count !== oldest_rsp.page_count)
               report_mismatch("page_count", rsp_bus.page_count, oldest_rsp.page_count);
            if (rsp_bus.total_count !== oldest_rsp.total_count)
               report_mismatch("total_count", rsp_bus.total_count, oldest_rsp.total_count);
            if (rsp_bus.out_of_range !== oldest_rsp.out_of_range)
               report_mismatch("out_of_range", rsp_bus.out_of_range, oldest_rsp.out_of_range);
         end
      end
   end

   initial begin
      #25ms;
      $display("tb: timeout with %0d results outstanding", expected_rsps.size());
      $display("tb: failure");
      $finish;
   end

   initial begin
      action_type            act;
      logic [15:0]           bidx;
      logic [PAGE_IDX_W-1:0] pidx;
      int unsigned           pick;

      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.action     = ACT_SET;
      req_bus.bit_index  = '0;
      req_bus.page_index = '0;
      send_idle_pct      = 17;
      rcv_idle_pct       = 61;
      mismatch_count     = 0;
      oor_tally          = 0;
      flip_tally         = 0;
      foreach (action_tally[i]) action_tally[i] = 0;
      foreach (shadow_words[i]) shadow_words[i] = '0;
      shadow_bits_set = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         send_op(directed_steps[i].action, directed_steps[i].bit_index,
                 directed_steps[i].page_index, directed_steps[i].fixed, directed_steps[i].rsp);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 61 : 0;
         rcv_idle_pct  = (phase == 0) ? 61 : (phase == 1) ? 17 : 0;
         repeat (RANDOM_OPS_PER_PHASE) begin
            pick = $urandom_range(99);
            act  = (pick < 45) ? ACT_SET : (pick < 80) ? ACT_RESET :
                   (pick < 97) ? ACT_COUNT : ACT_CLEAR;
            // dense low window and recent bits so resets and repeats hit set bits
            pick = $urandom_range(99);
            if (pick < 35)
               bidx = 16'($urandom_range(127));
            else if (pick < 55 && recent_set_bits.size() != 0)
               bidx = recent_set_bits[$urandom_range(recent_set_bits.size() - 1)];
            else if (pick < 90)
               bidx = 16'($urandom_range(32767));
            else
               bidx = 16'($urandom_range(65535, 32768));
            pidx = PAGE_IDX_W'(($urandom_range(99) < 80) ? $urandom_range(STORE_PAGES - 1)
                                                          : $urandom_range(31, STORE_PAGES));
            if (act == ACT_SET) begin
               recent_set_bits.push_back(bidx);
               if (recent_set_bits.size() > RECENT_DEPTH) void'(recent_set_bits.pop_front());
            end
            send_op(act, bidx, pidx, 1'b0, '0);
         end
      end
      req_bus.valid <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (STORE_WORDS + 8) @(posedge clock);

      $display("tb: %0d set, %0d reset, %0d count, %0d clear transfers",
               action_tally[ACT_SET], action_tally[ACT_RESET],
               action_tally[ACT_COUNT], action_tally[ACT_CLEAR]);
      $display("tb: %0d out of range, %0d bit flips, %0d mismatches",
               oor_tally, flip_tally, mismatch_count);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+sv
sv/bscp_pkg.sv
sv/bscp_if.sv
sv/bscp_ram.sv
sv/bscp_front.sv
sv/bscp_back.sv
sv/bitmap_set_clear_popcount_top.sv
dv/tb_bitmap_set_clear_popcount_top.sv
